[rtl/ppl_pkg.sv]
// ----------------------------------------------------------------------------
// ppl_pkg
// Shared types, codes and helpers of the predator-prey lattice update block.
// ----------------------------------------------------------------------------
package ppl_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int PROB_W  = 17;
    localparam int DRAW_W  = 16;
    localparam int CELL_W  = 2;
    localparam int OP_W    = 2;
    localparam int DIR_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int LANES   = 4;

    localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [CELL_W-1:0] CELL_NONE  = 2'd0;
    localparam logic [CELL_W-1:0] CELL_FISH  = 2'd1;
    localparam logic [CELL_W-1:0] CELL_SHARK = 2'd2;
    localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd3;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [DIR_W-1:0] DIR_ROW_INC = 2'd0;
    localparam logic [DIR_W-1:0] DIR_COL_INC = 2'd1;
    localparam logic [DIR_W-1:0] DIR_ROW_DEC = 2'd2;
    localparam logic [DIR_W-1:0] DIR_COL_DEC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SHARE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FISH_BIRTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FISH_DEATH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHARK_BIRTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHARK_STARVE = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_ISSUE,
        S_FOCAL,
        S_FISH,
        S_SCAN,
        S_VACATE,
        S_MIX_A,
        S_MIX_B,
        S_MIX_C,
        S_MIX_D,
        S_FINISH
    } state_t;

    function automatic logic [PROB_W-1:0] sat_prob(input logic [PROB_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

    function automatic logic [DIM_W-1:0] wrap_inc(input logic [DIM_W-1:0] pos,
                                                  input logic [DIM_W-1:0] dim);
        return (pos + 7'd1 == dim) ? '0 : pos + 7'd1;
    endfunction

    function automatic logic [DIM_W-1:0] wrap_dec(input logic [DIM_W-1:0] pos,
                                                  input logic [DIM_W-1:0] dim);
        return (pos == '0) ? dim - 7'd1 : pos - 7'd1;
    endfunction

endpackage

[rtl/ppl_reduce.sv]
// ----------------------------------------------------------------------------
// ppl_reduce
// Iterative remainder unit: four coordinate lanes reduced modulo the grid
// size, one restoring step per cycle.
// ----------------------------------------------------------------------------
module ppl_reduce
    import ppl_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [LANES-1:0][COORD_W-1:0]   value,
    input  logic [DIM_W-1:0]                rows_n,
    input  logic [DIM_W-1:0]                cols_n,
    output logic                            busy,
    output logic [LANES-1:0][COORD_W-1:0]   rem
);

    localparam int DIV_W  = DIM_W + COORD_W - 1;
    localparam int STEP_W = $clog2(COORD_W);

    logic [LANES-1:0][COORD_W-1:0] rem_reg;
    logic [LANES-1:0][COORD_W-1:0] rem_next;
    logic [DIV_W-1:0]              row_div_reg;
    logic [DIV_W-1:0]              col_div_reg;
    logic [STEP_W-1:0]             step_reg;
    logic                          busy_reg;

    always_comb
    begin
        logic [DIV_W-1:0] div_sel;
        logic [DIV_W-1:0] wide;
        logic [DIV_W-1:0] diff;
        for (int i = 0; i < LANES; i++)
        begin
            div_sel = (i % 2 == 0) ? row_div_reg : col_div_reg;
            wide    = {{(DIV_W-COORD_W){1'b0}}, rem_reg[i]};
            diff    = wide - div_sel;
            rem_next[i] = (wide >= div_sel) ? diff[COORD_W-1:0] : rem_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(COORD_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= value;
            row_div_reg <= {rows_n, {(COORD_W-1){1'b0}}};
            col_div_reg <= {cols_n, {(COORD_W-1){1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg     <= rem_next;
            row_div_reg <= row_div_reg >> 1;
            col_div_reg <= col_div_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

[rtl/predator_prey_lattice_update_top.sv]
// Each write, read or update first passes coordinate reduction, then performs its
// grid memory accesses, one grid memory access a cycle, and registers the result.
// Throughput: one transaction at a time; the next is taken once the result is
// registered, so the gap between items is set by the single memory port.
// Reset clears control and returns configuration to its defaults; grid contents
// stay undefined until written.
// ----------------------------------------------------------------------------
// predator_prey_lattice_update_top
// Toroidal fish/shark lattice in one grid memory: cell write, cell read and
// one random cell update with mixing swap, done by read-modify-write.
// ----------------------------------------------------------------------------
module predator_prey_lattice_update_top
    import ppl_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PROB_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   col,
    input  logic [CELL_W-1:0]    cell_value,
    input  logic [DIR_W-1:0]     direction,
    input  logic [DRAW_W-1:0]    draw_main,
    input  logic [DRAW_W-1:0]    draw_breed,
    input  logic [DRAW_W-1:0]    draw_mix,
    input  logic [COORD_W-1:0]   mix_row,
    input  logic [COORD_W-1:0]   mix_col,
    input  logic [DIR_W-1:0]     mix_direction,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CELL_W-1:0]    cell_state
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [DIM_W-1:0]  rows_used_reg;
    logic [DIM_W-1:0]  cols_used_reg;
    logic [PROB_W-1:0] step_share_reg;
    logic [PROB_W-1:0] fish_birth_reg;
    logic [PROB_W-1:0] fish_death_reg;
    logic [PROB_W-1:0] shark_birth_reg;
    logic [PROB_W-1:0] shark_starve_reg;

    state_t state_reg;
    state_t state_next;

    logic [OP_W-1:0]   op_reg;
    logic [CELL_W-1:0] val_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic [DRAW_W-1:0] draw_main_reg;
    logic [DRAW_W-1:0] draw_breed_reg;
    logic [DRAW_W-1:0] draw_mix_reg;
    logic [DIR_W-1:0]  mix_dir_reg;
    logic [DIR_W-1:0]  scan_k_reg;
    logic [CELL_W-1:0] mix_a_val_reg;
    logic [CELL_W-1:0] res_reg;
    logic              out_valid_reg;
    logic [CELL_W-1:0] cell_state_reg;

    logic [CELL_W-1:0] grid_mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic                          in_accept;
    logic                          reduce_busy;
    logic [LANES-1:0][COORD_W-1:0] reduce_value;
    logic [LANES-1:0][COORD_W-1:0] reduce_rem;
    logic [DIM_W-1:0]              rows_n;
    logic [DIM_W-1:0]              cols_n;
    logic                          out_load;

    logic [DIM_W-1:0]  foc_r;
    logic [DIM_W-1:0]  foc_c;
    logic [DIM_W-1:0]  mix_r;
    logic [DIM_W-1:0]  mix_c;
    logic [DIR_W-1:0]  scan_dir;
    logic [DIR_W-1:0]  scan_dir_nxt;
    logic [ADDR_W-1:0] focal_addr;
    logic [ADDR_W-1:0] nbr_addr;
    logic [ADDR_W-1:0] nbr_nxt_addr;
    logic [ADDR_W-1:0] mix_a_addr;
    logic [ADDR_W-1:0] mix_b_addr;

    logic grow_hit;
    logic death_hit;
    logic eat_hit;
    logic breed_hit;
    logic starve_hit;
    logic mix_hit;
    logic out_free;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                    input logic [DIM_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS)) + ADDR_W'(c);
    endfunction

    function automatic logic [ADDR_W-1:0] nbr_cell(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c,
                                                   input logic [DIR_W-1:0] d,
                                                   input logic [DIM_W-1:0] nr,
                                                   input logic [DIM_W-1:0] nc);
        logic [DIM_W-1:0] tr;
        logic [DIM_W-1:0] tc;
        tr = r;
        tc = c;
        unique case (d)
            DIR_ROW_INC: tr = wrap_inc(r, nr);
            DIR_COL_INC: tc = wrap_inc(c, nc);
            DIR_ROW_DEC: tr = wrap_dec(r, nr);
            DIR_COL_DEC: tc = wrap_dec(c, nc);
            default:     tr = r;
        endcase
        return cell_addr(tr, tc);
    endfunction

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg    <= 7'd64;
            cols_used_reg    <= 7'd64;
            step_share_reg   <= ONE_Q16;
            fish_birth_reg   <= '0;
            fish_death_reg   <= '0;
            shark_birth_reg  <= '0;
            shark_starve_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_USED:    rows_used_reg    <= cfg_data[DIM_W-1:0];
                REG_COLS_USED:    cols_used_reg    <= cfg_data[DIM_W-1:0];
                REG_STEP_SHARE:   step_share_reg   <= sat_prob(cfg_data);
                REG_FISH_BIRTH:   fish_birth_reg   <= sat_prob(cfg_data);
                REG_FISH_DEATH:   fish_death_reg   <= sat_prob(cfg_data);
                REG_SHARK_BIRTH:  shark_birth_reg  <= sat_prob(cfg_data);
                REG_SHARK_STARVE: shark_starve_reg <= sat_prob(cfg_data);
                default:          rows_used_reg    <= rows_used_reg;
            endcase
        end
    end

    assign rows_n = (rows_used_reg == '0) ? 7'd1 :
                    (32'(rows_used_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_used_reg;
    assign cols_n = (cols_used_reg == '0) ? 7'd1 :
                    (32'(cols_used_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_used_reg;

    // Coordinate reduction
    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign reduce_value = {mix_col, mix_row, col, row};

    ppl_reduce u_reduce
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .value  (reduce_value),
        .rows_n (rows_n),
        .cols_n (cols_n),
        .busy   (reduce_busy),
        .rem    (reduce_rem)
    );

    assign foc_r = {1'b0, reduce_rem[0]};
    assign foc_c = {1'b0, reduce_rem[1]};
    assign mix_r = {1'b0, reduce_rem[2]};
    assign mix_c = {1'b0, reduce_rem[3]};

    assign scan_dir     = dir_reg + scan_k_reg;
    assign scan_dir_nxt = scan_dir + 2'd1;

    assign focal_addr   = cell_addr(foc_r, foc_c);
    assign nbr_addr     = nbr_cell(foc_r, foc_c, scan_dir, rows_n, cols_n);
    assign nbr_nxt_addr = nbr_cell(foc_r, foc_c, scan_dir_nxt, rows_n, cols_n);
    assign mix_a_addr   = cell_addr(mix_r, mix_c);
    assign mix_b_addr   = nbr_cell(mix_r, mix_c, mix_dir_reg, rows_n, cols_n);

    // Draw tests
    assign grow_hit   = {1'b0, draw_main_reg} < fish_birth_reg;
    assign death_hit  = ({2'b0, draw_main_reg} + {1'b0, fish_death_reg})
                        > {1'b0, step_share_reg};
    assign eat_hit    = {1'b0, draw_main_reg} < step_share_reg;
    assign breed_hit  = {1'b0, draw_breed_reg} >= shark_birth_reg;
    assign starve_hit = {1'b0, draw_main_reg} < shark_starve_reg;
    assign mix_hit    = {1'b0, draw_mix_reg} < step_share_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (!reduce_busy)
                    state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (op_reg == OP_READ || op_reg == OP_UPDATE)
                    state_next = S_FOCAL;
                else
                    state_next = S_FINISH;
            end
            S_FOCAL:
            begin
                if (op_reg == OP_READ)
                    state_next = S_FINISH;
                else if (rd_data_reg == CELL_FISH && grow_hit)
                    state_next = S_FISH;
                else if (rd_data_reg == CELL_SHARK)
                    state_next = S_SCAN;
                else
                    state_next = S_MIX_A;
            end
            S_FISH:
                state_next = S_MIX_A;
            S_SCAN:
            begin
                if (rd_data_reg == CELL_FISH)
                    state_next = (eat_hit && breed_hit) ? S_VACATE : S_MIX_A;
                else if (scan_k_reg == 2'd3)
                    state_next = S_MIX_A;
            end
            S_VACATE:
                state_next = S_MIX_A;
            S_MIX_A:
                state_next = mix_hit ? S_MIX_B : S_FINISH;
            S_MIX_B:
                state_next = S_MIX_C;
            S_MIX_C:
                state_next = S_MIX_D;
            S_MIX_D:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Memory control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = focal_addr;
        mem_wdata = CELL_EMPTY;
        mem_re    = 1'b0;
        mem_raddr = focal_addr;
        out_load  = 1'b0;
        unique case (state_reg)
            S_ISSUE:
            begin
                if (op_reg == OP_WRITE)
                begin
                    mem_we    = (val_reg != CELL_NONE);
                    mem_wdata = val_reg;
                end
                else if (op_reg == OP_READ || op_reg == OP_UPDATE)
                    mem_re = 1'b1;
            end
            S_FOCAL:
            begin
                if (op_reg == OP_UPDATE && rd_data_reg == CELL_FISH)
                begin
                    if (grow_hit)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = nbr_addr;
                    end
                    else
                        mem_we = death_hit;
                end
                else if (op_reg == OP_UPDATE && rd_data_reg == CELL_SHARK)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = nbr_addr;
                end
            end
            S_FISH:
            begin
                mem_we    = (rd_data_reg == CELL_EMPTY);
                mem_waddr = nbr_addr;
                mem_wdata = CELL_FISH;
            end
            S_SCAN:
            begin
                if (rd_data_reg == CELL_FISH)
                begin
                    mem_we    = eat_hit;
                    mem_waddr = nbr_addr;
                    mem_wdata = CELL_SHARK;
                end
                else if (scan_k_reg == 2'd3)
                    mem_we = starve_hit;
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = nbr_nxt_addr;
                end
            end
            S_VACATE:
                mem_we = 1'b1;
            S_MIX_A:
            begin
                mem_re    = mix_hit;
                mem_raddr = mix_a_addr;
            end
            S_MIX_B:
            begin
                mem_re    = 1'b1;
                mem_raddr = mix_b_addr;
            end
            S_MIX_C:
            begin
                mem_we    = 1'b1;
                mem_waddr = mix_a_addr;
                mem_wdata = rd_data_reg;
            end
            S_MIX_D:
            begin
                mem_we    = 1'b1;
                mem_waddr = mix_b_addr;
                mem_wdata = mix_a_val_reg;
            end
            S_FINISH:
                out_load = out_free;
            default:
                out_load = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= grid_mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_k_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
                scan_k_reg <= '0;
            else if (state_reg == S_SCAN && mem_re)
                scan_k_reg <= scan_k_reg + 2'd1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg         <= operation;
            val_reg        <= cell_value;
            dir_reg        <= direction;
            draw_main_reg  <= draw_main;
            draw_breed_reg <= draw_breed;
            draw_mix_reg   <= draw_mix;
            mix_dir_reg    <= mix_direction;
            res_reg        <= CELL_NONE;
        end
        else if (state_reg == S_FOCAL && op_reg == OP_READ)
            res_reg <= rd_data_reg;
        if (state_reg == S_MIX_B)
            mix_a_val_reg <= rd_data_reg;
        if (out_load)
            cell_state_reg <= res_reg;
    end

    assign out_valid  = out_valid_reg;
    assign cell_state = cell_state_reg;

    a_accept_starts_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == S_REDUCE) && reduce_busy)
        else $error("accepted transaction did not start coordinate reduction");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("grid written while idle");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("grid read and write in the same cycle");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result raised outside the finishing state");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        reduce_busy |-> in_stall)
        else $error("input open during coordinate reduction");

endmodule
